[rtl/slr_pkg.sv]
// Shared types and constants for the stereo linear resampler.
// No dependencies; imported by every module of the block.
package slr_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int FRAC_BITS = 16;
	localparam int PHASE_W   = FRAC_BITS + 4;
	localparam int STEP_W    = 18;
	localparam int BLK_W     = 10;
	localparam int BUF_COUNT = 4;
	localparam int BUF_W     = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 18;
	localparam int PROD_W    = SAMPLE_W + FRAC_BITS + 2;
	localparam int NUM_W     = SAMPLE_W + FRAC_BITS + 3;

	localparam logic [PHASE_W-1:0] ONE_PHASE = PHASE_W'(1) << FRAC_BITS;
	localparam logic [STEP_W-1:0]  MIN_STEP  = STEP_W'(1) << (FRAC_BITS - 4);

	localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(65536);
	localparam logic [BLK_W-1:0]  BLK_RST  = BLK_W'(800);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SAMPLES = CFG_IDX_W'(1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
		logic                       call_end;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
		logic                       block_end;
		logic [BUF_W-1:0]           buffer_number;
		logic                       run_last;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load_input;
		logic load_prod;
		logic emit_lerp;
		logic emit_hold;
		logic run_last;
		logic wrap_phase;
		logic clear_phase;
		logic commit;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic phase_in;       // phase < one sample
		logic next_in;        // phase + step < one sample
		logic next_twice_out; // phase + step >= two samples
		logic out_free;       // output register can take a result
	} dp_sts_t;

endpackage

[rtl/stereo_linear_resampler_unit.sv]
// Top level of the stereo linear-interpolation resampler.
// Depends on slr_pkg, slr_ctrl and slr_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | in_data  (left_in, right_in, call_end)
//  output   | out_valid / out_stall| out_data (left_out, right_out, block_end,
//           |                      |           buffer_number, run_last)
//  config   | cfg_we               | cfg_index, cfg_data (no read-back)
//
// A pair that follows a stored previous pair runs accept, then a check and an issue
// step per interpolated output, a final check and the commit; the first pair of a
// transfer has no interpolation checks and runs accept, then commit.
// A call_end pair adds a hold step per held output and a final hold check.
// The split into check and issue steps per output is set by the
// registered multiplier stage ahead of the output register.
// Reset clears phase, block counter, buffer index and the previous-pair flag;
// the input side is stalled during reset and until ready_q is registered after it.
// Output stalls freeze the sequencer at the next result; the next input
// transaction is taken while the last result still waits in the output register.
module stereo_linear_resampler_unit import slr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: one input at a time, one result per emit command
	slr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_call_end (in_data.call_end),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.sts         (sts)
	);

	// phase accumulator, two 17x17 multipliers, block counter, output register
	slr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

[rtl/slr_datapath.sv]
// Datapath: config registers, sample store, phase, interpolation multipliers,
// block counter and output register. Depends on slr_pkg.
module slr_datapath import slr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  in_item_t             in_data,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data
);

	logic [STEP_W-1:0]  phase_step_q;
	logic [BLK_W-1:0]   block_samples_q;
	logic [PHASE_W-1:0] phase_q;
	logic [BLK_W-1:0]   block_fill_q;
	logic [BUF_W-1:0]   cur_buf_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic signed [SAMPLE_W-1:0] cur_l_q, cur_r_q, prev_l_q, prev_r_q;
	logic signed [PROD_W-1:0]   prod_l_s1, prod_r_s1;

	logic [STEP_W-1:0]        step_eff;
	logic [PHASE_W-1:0]       phase_next;
	logic signed [SAMPLE_W:0] diff_l, diff_r;
	logic signed [FRAC_BITS:0] frac_s;
	logic signed [SAMPLE_W-1:0] lerp_l, lerp_r;
	logic [BLK_W-1:0]         blk_size;
	logic [BLK_W:0]           fill_inc;
	logic                     blk_end;
	logic                     emit;

	function automatic logic signed [SAMPLE_W-1:0] lerp_finish(
		input logic signed [SAMPLE_W-1:0] a,
		input logic signed [PROD_W-1:0]   prod
	);
		logic signed [NUM_W-1:0] num;
		logic signed [NUM_W-1:0] rnd;
		num = (NUM_W'(a) <<< FRAC_BITS) + NUM_W'(prod);
		// truncate toward zero: bias negatives before dropping the fraction
		rnd = num + (num[NUM_W-1] ? NUM_W'(ONE_PHASE - 1'b1) : NUM_W'(0));
		return rnd[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
	endfunction

	assign step_eff   = (phase_step_q < MIN_STEP) ? MIN_STEP : phase_step_q;
	assign phase_next = phase_q + PHASE_W'(step_eff);

	assign sts.phase_in       = phase_q < ONE_PHASE;
	assign sts.next_in        = phase_next < ONE_PHASE;
	assign sts.next_twice_out = phase_next >= (ONE_PHASE << 1);
	assign sts.out_free       = !out_valid_q || !out_stall;

	assign diff_l = (SAMPLE_W+1)'(cur_l_q) - (SAMPLE_W+1)'(prev_l_q);
	assign diff_r = (SAMPLE_W+1)'(cur_r_q) - (SAMPLE_W+1)'(prev_r_q);
	assign frac_s = $signed({1'b0, phase_q[FRAC_BITS-1:0]});

	assign lerp_l = lerp_finish(prev_l_q, prod_l_s1);
	assign lerp_r = lerp_finish(prev_r_q, prod_r_s1);

	assign blk_size = (block_samples_q == '0) ? BLK_W'(1) : block_samples_q;
	assign fill_inc = {1'b0, block_fill_q} + (BLK_W+1)'(1);
	assign blk_end  = fill_inc >= {1'b0, blk_size};
	assign emit     = cmd.emit_lerp || cmd.emit_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q    <= STEP_RST;
			block_samples_q <= BLK_RST;
			phase_q         <= '0;
			block_fill_q    <= '0;
			cur_buf_q       <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PHASE_STEP:    phase_step_q    <= cfg_data[STEP_W-1:0];
					REG_BLOCK_SAMPLES: block_samples_q <= cfg_data[BLK_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clear_phase) begin
				phase_q <= '0;
			end else if (cmd.wrap_phase) begin
				phase_q <= phase_q - ONE_PHASE;
			end else if (emit) begin
				phase_q <= phase_next;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				if (blk_end) begin
					block_fill_q <= '0;
					cur_buf_q    <= (cur_buf_q == BUF_W'(BUF_COUNT - 1)) ? '0
						: cur_buf_q + BUF_W'(1);
				end else begin
					block_fill_q <= fill_inc[BLK_W-1:0];
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_input) begin
			cur_l_q <= in_data.left_in;
			cur_r_q <= in_data.right_in;
		end
		if (cmd.commit) begin
			prev_l_q <= cur_l_q;
			prev_r_q <= cur_r_q;
		end
		if (cmd.load_prod) begin
			prod_l_s1 <= diff_l * frac_s;
			prod_r_s1 <= diff_r * frac_s;
		end
		if (emit) begin
			out_q.left_out      <= cmd.emit_hold ? cur_l_q : lerp_l;
			out_q.right_out     <= cmd.emit_hold ? cur_r_q : lerp_r;
			out_q.block_end     <= blk_end;
			out_q.buffer_number <= cur_buf_q;
			out_q.run_last      <= cmd.run_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/slr_ctrl.sv]
// Controller: sequences input capture, interpolation and hold intervals,
// and the end-of-item commit. Depends on slr_pkg.
module slr_ctrl import slr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_call_end,
	output logic    in_stall,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LERP_CHK,
		ST_LERP_OUT,
		ST_HOLD,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   ready_q;
	logic   end_q;
	logic   have_prev_q;
	logic   accept;

	assign accept   = in_valid && ready_q;
	assign in_stall = !ready_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_input = 1'b1;
					if (have_prev_q) begin
						state_d = ST_LERP_CHK;
					end else if (in_call_end) begin
						state_d = ST_HOLD;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_LERP_CHK: begin
				cmd.load_prod = 1'b1;
				if (sts.phase_in) begin
					state_d = ST_LERP_OUT;
				end else begin
					cmd.wrap_phase = 1'b1;
					state_d = end_q ? ST_HOLD : ST_FINISH;
				end
			end
			ST_LERP_OUT: begin
				if (sts.out_free) begin
					cmd.emit_lerp = 1'b1;
					// last unless more positions follow here or in the hold interval
					cmd.run_last  = !sts.next_in && !(end_q && !sts.next_twice_out);
					state_d       = ST_LERP_CHK;
				end
			end
			ST_HOLD: begin
				if (sts.phase_in) begin
					if (sts.out_free) begin
						cmd.emit_hold = 1'b1;
						cmd.run_last  = !sts.next_in;
					end
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.commit      = 1'b1;
				cmd.clear_phase = end_q;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ready_q     <= 1'b0;
			end_q       <= 1'b0;
			have_prev_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == ST_IDLE);
			if (accept) begin
				end_q <= in_call_end;
			end
			if (cmd.commit) begin
				have_prev_q <= !end_q;
			end
		end
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_lerp || cmd.emit_hold) |-> sts.out_free)
		else $error("result issued while output register is occupied");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_lerp, cmd.emit_hold, cmd.wrap_phase, cmd.commit, cmd.load_input}))
		else $error("conflicting datapath commands");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (state_q == ST_IDLE))
		else $error("input ready outside idle");

	a_lerp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_lerp |-> sts.phase_in)
		else $error("interpolation at phase of one sample or more");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !ready_q)
		else $error("ready held after input transaction");

endmodule
